@@ hdl/bpa_pkg.sv @@
package bpa_pkg;

	localparam int PAGE_W      = 12;
	localparam int PAGE_COUNT  = 1 << PAGE_W;
	localparam int ORDER_COUNT = 11;
	localparam int ORD_W       = 4;
	localparam int LINK_W      = PAGE_W + 1;
	localparam int MARK_W      = ORD_W + 1;

	// null link: page count itself, only the top bit set
	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(PAGE_COUNT);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLR,
		OP_LOAD,
		OP_WINC,
		OP_POP,
		OP_UNLINK,
		OP_SPLIT,
		OP_BUDDY,
		OP_MERGE,
		OP_SELF,
		OP_PUSH1,
		OP_PUSH2,
		OP_RESULT,
		OP_FAIL
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic ord_ok;
		logic action;
		logic head_valid;
		logic w_top;
		logic w_gt_t;
		logic split_ok;
		logic can_merge;
		logic buddy_match;
		logic out_free;
	} stat_t;

endpackage

@@ hdl/bpa_dpath.sv @@
module bpa_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bpa_pkg::cmd_t               cmd,
	output bpa_pkg::stat_t              st,
	input  logic                        in_action,
	input  logic [bpa_pkg::ORD_W-1:0]   in_order,
	input  logic [bpa_pkg::PAGE_W-1:0]  in_page,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bpa_pkg::PAGE_W-1:0]  out_page,
	output logic                        out_fail
);

	localparam int PW = bpa_pkg::PAGE_W;
	localparam int OW = bpa_pkg::ORD_W;
	localparam int LW = bpa_pkg::LINK_W;
	localparam int MW = bpa_pkg::MARK_W;

	logic [LW-1:0] next_mem [bpa_pkg::PAGE_COUNT];
	logic [LW-1:0] prev_mem [bpa_pkg::PAGE_COUNT];
	logic [MW-1:0] mark_mem [bpa_pkg::PAGE_COUNT];

	logic [LW-1:0] head_q [bpa_pkg::ORDER_COUNT];

	logic          action_q;
	logic [PW-1:0] page_q;
	logic [PW-1:0] p_q;
	logic [PW-1:0] x_q;
	logic [OW-1:0] w_q;
	logic [OW-1:0] t_q;
	logic [PW-1:0] clr_cnt_q;
	logic [LW-1:0] next_rd_q;
	logic [LW-1:0] prev_rd_q;
	logic [MW-1:0] mark_rd_q;
	logic          out_valid_q;
	logic [PW-1:0] out_page_q;
	logic          out_fail_q;

	logic [LW-1:0] head_w;
	logic [OW-1:0] w_dec;
	logic [LW-1:0] half;
	logic [PW-1:0] bit_w;
	logic          do_unlink;

	logic          next_we, prev_we, mark_we;
	logic [PW-1:0] next_wa, prev_wa, mark_wa;
	logic [LW-1:0] next_wd, prev_wd;
	logic [MW-1:0] mark_wd;

	assign head_w    = (w_q < OW'(bpa_pkg::ORDER_COUNT)) ? head_q[w_q] : bpa_pkg::NIL_LINK;
	assign w_dec     = w_q - OW'(1);
	assign half      = {1'b0, p_q} + (LW'(1) << w_dec);
	assign bit_w     = PW'(1) << w_q;
	assign do_unlink = (cmd.op == bpa_pkg::OP_UNLINK) || (cmd.op == bpa_pkg::OP_MERGE);

	always_comb begin
		st.clr_last    = &clr_cnt_q;
		st.ord_ok      = t_q < OW'(bpa_pkg::ORDER_COUNT);
		st.action      = action_q;
		st.head_valid  = !head_w[LW-1];
		st.w_top       = w_q == OW'(bpa_pkg::ORDER_COUNT - 1);
		st.w_gt_t      = w_q > t_q;
		st.split_ok    = !half[LW-1];
		st.can_merge   = w_q < OW'(bpa_pkg::ORDER_COUNT - 1);
		st.buddy_match = mark_rd_q == {1'b1, w_q};
		st.out_free    = !out_valid_q || out_ready;
	end

	// write ports, one per memory
	always_comb begin
		next_we = 1'b0; next_wa = x_q; next_wd = head_w;
		prev_we = 1'b0; prev_wa = x_q; prev_wd = bpa_pkg::NIL_LINK;
		mark_we = 1'b0; mark_wa = x_q; mark_wd = '0;
		case (cmd.op)
			bpa_pkg::OP_UNLINK, bpa_pkg::OP_MERGE: begin
				next_we = !prev_rd_q[LW-1];
				next_wa = prev_rd_q[PW-1:0];
				next_wd = next_rd_q;
				prev_we = !next_rd_q[LW-1];
				prev_wa = next_rd_q[PW-1:0];
				prev_wd = prev_rd_q;
				mark_we = 1'b1;
			end
			bpa_pkg::OP_PUSH1: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				mark_we = 1'b1;
				mark_wd = {1'b1, w_q};
			end
			bpa_pkg::OP_PUSH2: begin
				prev_we = !head_w[LW-1];
				prev_wa = head_w[PW-1:0];
				prev_wd = {1'b0, x_q};
			end
			bpa_pkg::OP_CLR: begin
				mark_we = 1'b1;
				mark_wa = clr_cnt_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		if (mark_we) mark_mem[mark_wa] <= mark_wd;
		next_rd_q <= next_mem[x_q];
		prev_rd_q <= prev_mem[x_q];
		mark_rd_q <= mark_mem[x_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bpa_pkg::ORDER_COUNT; i++) head_q[i] <= bpa_pkg::NIL_LINK;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == bpa_pkg::OP_CLR) clr_cnt_q <= clr_cnt_q + PW'(1);
			if (do_unlink && prev_rd_q[LW-1]) head_q[w_q] <= next_rd_q;
			if (cmd.op == bpa_pkg::OP_PUSH2) head_q[w_q] <= {1'b0, x_q};
			if (cmd.op == bpa_pkg::OP_RESULT || cmd.op == bpa_pkg::OP_FAIL)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			bpa_pkg::OP_LOAD: begin
				action_q <= in_action;
				page_q   <= in_page;
				p_q      <= in_page;
				w_q      <= in_order;
				t_q      <= in_order;
			end
			bpa_pkg::OP_WINC: w_q <= w_q + OW'(1);
			bpa_pkg::OP_POP: begin
				p_q <= head_w[PW-1:0];
				x_q <= head_w[PW-1:0];
			end
			bpa_pkg::OP_SPLIT: begin
				w_q <= w_dec;
				x_q <= half[PW-1:0];
			end
			bpa_pkg::OP_BUDDY: x_q <= p_q ^ bit_w;
			bpa_pkg::OP_MERGE: begin
				p_q <= p_q & ~bit_w;
				w_q <= w_q + OW'(1);
			end
			bpa_pkg::OP_SELF: x_q <= p_q;
			bpa_pkg::OP_RESULT: begin
				out_page_q <= action_q ? page_q : p_q;
				out_fail_q <= 1'b0;
			end
			bpa_pkg::OP_FAIL: begin
				out_page_q <= action_q ? page_q : '0;
				out_fail_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_page  = out_page_q;
	assign out_fail  = out_fail_q;

	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bpa_pkg::OP_RESULT || cmd.op == bpa_pkg::OP_FAIL) |=> out_valid_q)
		else $error("result not presented");
	a_clr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bpa_pkg::OP_CLR) |=> clr_cnt_q == $past(clr_cnt_q) + PW'(1))
		else $error("clear counter skipped");
	a_merge_up: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bpa_pkg::OP_MERGE) |=> w_q == $past(w_q) + OW'(1))
		else $error("merge did not raise order");

endmodule

@@ hdl/bpa_ctrl.sv @@
module bpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bpa_pkg::stat_t st,
	output bpa_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_DECIDE, ST_SEARCH, ST_RD, ST_UNL, ST_SPLIT,
		ST_MCHK, ST_MRD, ST_MTST, ST_PUSH1, ST_PUSH2, ST_FIN_OK, ST_FIN_FAIL
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd.op  = bpa_pkg::OP_NONE;
		unique case (state_q)
			ST_CLR: begin
				cmd.op = bpa_pkg::OP_CLR;
				if (st.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = bpa_pkg::OP_LOAD;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!st.ord_ok) state_d = ST_FIN_FAIL;
				else if (st.action) state_d = ST_MCHK;
				else state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (st.head_valid) begin
					cmd.op  = bpa_pkg::OP_POP;
					state_d = ST_RD;
				end else if (st.w_top) begin
					state_d = ST_FIN_FAIL;
				end else begin
					cmd.op = bpa_pkg::OP_WINC;
				end
			end
			ST_RD: state_d = ST_UNL;
			ST_UNL: begin
				cmd.op  = bpa_pkg::OP_UNLINK;
				state_d = ST_SPLIT;
			end
			ST_SPLIT: begin
				if (st.w_gt_t) begin
					cmd.op = bpa_pkg::OP_SPLIT;
					if (st.split_ok) state_d = ST_PUSH1;
				end else begin
					state_d = ST_FIN_OK;
				end
			end
			ST_MCHK: begin
				if (st.can_merge) begin
					cmd.op  = bpa_pkg::OP_BUDDY;
					state_d = ST_MRD;
				end else begin
					cmd.op  = bpa_pkg::OP_SELF;
					state_d = ST_PUSH1;
				end
			end
			ST_MRD: state_d = ST_MTST;
			ST_MTST: begin
				if (st.buddy_match) begin
					cmd.op  = bpa_pkg::OP_MERGE;
					state_d = ST_MCHK;
				end else begin
					cmd.op  = bpa_pkg::OP_SELF;
					state_d = ST_PUSH1;
				end
			end
			ST_PUSH1: begin
				cmd.op  = bpa_pkg::OP_PUSH1;
				state_d = ST_PUSH2;
			end
			ST_PUSH2: begin
				cmd.op  = bpa_pkg::OP_PUSH2;
				state_d = st.action ? ST_FIN_OK : ST_SPLIT;
			end
			ST_FIN_OK: begin
				if (st.out_free) begin
					cmd.op  = bpa_pkg::OP_RESULT;
					state_d = ST_IDLE;
				end
			end
			ST_FIN_FAIL: begin
				if (st.out_free) begin
					cmd.op  = bpa_pkg::OP_FAIL;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = state_q == ST_IDLE;

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> state_q == ST_DECIDE)
		else $error("accepted item not decoded");
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH1) |=> state_q == ST_PUSH2)
		else $error("push split");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR && !st.clr_last) |=> state_q == ST_CLR)
		else $error("clear pass cut short");

endmodule

@@ hdl/buddy_page_allocator.sv @@
// channel | dir | tdata (low bit up)                          | tuser
// s_*     | in  | block_order[3:0], page_index[15:4]          | action[0]
// m_*     | out | result_page[11:0], zero pad [15:12]         | failed[0]
//
// After reset a clearing pass zeroes the page marks, with s_tready low.
// One request at a time: alloc searches upward from the requested order,
// pops and unlinks a block, then splits it down, pushing each upper half;
// free probes the buddy at each order below 10 and merges while that buddy
// is free at the same order, then pushes the block; then the result is presented.
// The link and mark memories each have one write port and one read port.
// A waiting result does not block
// the next transfer in; the finish step waits only for the output slot.
module buddy_page_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // block_order[3:0], page_index[15:4]
	input  logic [0:0]  s_tuser,  // action[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // result_page[11:0], zero [15:12]
	output logic [0:0]  m_tuser   // failed[0]
);

	bpa_pkg::cmd_t  cmd;
	bpa_pkg::stat_t st;
	logic [bpa_pkg::PAGE_W-1:0] out_page;
	logic out_fail;

	// sequencer
	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// lists, link and mark memories, result register
	bpa_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_action (s_tuser[0]),
		.in_order  (s_tdata[3:0]),
		.in_page   (s_tdata[15:4]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_page  (out_page),
		.out_fail  (out_fail)
	);

	assign m_tdata = {4'b0, out_page};
	assign m_tuser = out_fail;

endmodule
